// ===== rtl/core/wpet_pkg.sv =====
// shared types and constants for the escape tokenizer
// no dependencies; imported by every module of the block
package wpet_pkg;

  typedef enum logic [1:0] {
    MODE_PLAIN = 2'd0,
    MODE_HTML  = 2'd1,
    MODE_RTF   = 2'd2
  } mode_e;

  typedef enum logic [3:0] {
    TOK_CHAR      = 4'd0,
    TOK_LINEBREAK = 4'd1,
    TOK_PAGEBREAK = 4'd2,
    TOK_BRACE     = 4'd3,
    TOK_FONTSIZE  = 4'd4,
    TOK_STYLE_OFF = 4'd5,
    TOK_STYLE_ON  = 4'd6,
    TOK_PARAGRAPH = 4'd7,
    TOK_IMAGE     = 4'd8
  } tok_kind_e;

  // escape and control bytes
  localparam logic [7:0] BYTE_NUL      = 8'h00;
  localparam logic [7:0] BYTE_FORMFEED = 8'h0c;
  localparam logic [7:0] BYTE_CR       = 8'h0d;
  localparam logic [7:0] BYTE_GRAPHIC  = 8'h10;
  localparam logic [7:0] BYTE_RULER    = 8'h11;
  localparam logic [7:0] BYTE_CARD     = 8'h17;
  localparam logic [7:0] BYTE_SKIP_A   = 8'h08;
  localparam logic [7:0] BYTE_SKIP_B   = 8'h18;
  localparam logic [7:0] BYTE_SKIP_C   = 8'hF5;
  localparam logic [7:0] BYTE_LBRACE   = 8'h7B;
  localparam logic [7:0] BYTE_RBRACE   = 8'h7D;

  localparam int SkipW  = 5;
  localparam int SizeW  = 5;
  localparam int StyleW = 7;  // style bits 1..7, bit 0 never reported

  localparam logic [SkipW-1:0] SKIP_HEADER  = 5'd19;
  localparam logic [SkipW-1:0] SKIP_ESCAPE  = 5'd19;
  localparam logic [SkipW-1:0] SKIP_GRAPHIC = 5'd4;
  localparam logic [SkipW-1:0] SKIP_RULER   = 5'd26;
  localparam logic [SkipW-1:0] SKIP_LONG    = 5'd10;

  localparam int FifoDepth = 4;
  localparam int FifoAw    = 2;

  // one queued command: a single token, or a font/style card to expand
  typedef struct packed {
    logic              is_card;
    tok_kind_e         kind;
    logic [7:0]        value;     // char byte, or new font size for a card
    logic              size_chg;
    logic [StyleW-1:0] off_mask;
    logic [StyleW-1:0] on_mask;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

endpackage

// ===== rtl/core/wpet_front.sv =====
// front end: accepts bytes, tracks skip/capture state, classifies into commands
// depends on wpet_pkg
module wpet_front (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_data_i,
  input  logic               in_valid_i,
  input  logic [7:0]         data_byte_i,
  input  logic               chain_start_i,
  output logic               in_ready_o,
  output logic               push_o,
  output wpet_pkg::cmd_t     cmd_o,
  input  wpet_pkg::fifo_stat_t stat_i
);
  import wpet_pkg::*;

  mode_e             mode_q;
  logic [SkipW-1:0]  skip_q, skip_d;
  logic              capturing_q, capturing_d;
  logic [1:0]        cap_idx_q, cap_idx_d;
  logic [SizeW-1:0]  font_lo_q, font_lo_d;
  logic [StyleW-1:0] style_q, style_d;
  logic [SizeW-1:0]  size_q, size_d;
  logic              accept, has_tok, styled;
  logic [StyleW-1:0] card_style;
  cmd_t              cmd;

  assign in_ready_o = !stat_i.full;
  assign accept     = in_valid_i && !stat_i.full;
  assign styled     = (mode_q == MODE_HTML) || (mode_q == MODE_RTF);
  assign card_style = data_byte_i[7:1];

  always_comb begin
    skip_d      = skip_q;
    capturing_d = capturing_q;
    cap_idx_d   = cap_idx_q;
    font_lo_d   = font_lo_q;
    style_d     = style_q;
    size_d      = size_q;
    has_tok     = 1'b0;
    cmd         = '0;
    cmd.kind    = TOK_CHAR;
    cmd.value   = data_byte_i;
    if (accept) begin
      if (chain_start_i) begin
        skip_d      = '0;
        capturing_d = 1'b0;
        cap_idx_d   = '0;
        style_d     = '0;
        size_d      = '0;
      end
      if (skip_d != '0) begin
        skip_d = skip_d - SkipW'(1);
      end else if (capturing_d) begin
        case (cap_idx_d)
          2'd0: begin
            font_lo_d = data_byte_i[SizeW-1:0];
            cap_idx_d = 2'd1;
          end
          2'd1: begin
            cap_idx_d = 2'd2;
          end
          default: begin
            capturing_d = 1'b0;
            cap_idx_d   = '0;
            if (styled) begin
              cmd.is_card  = 1'b1;
              cmd.kind     = TOK_FONTSIZE;
              cmd.value    = {{(8-SizeW){1'b0}}, font_lo_d};
              cmd.size_chg = (font_lo_d != size_d);
              cmd.off_mask = style_d & ~card_style;
              cmd.on_mask  = ~style_d & card_style;
              has_tok      = cmd.size_chg || (cmd.off_mask != '0) || (cmd.on_mask != '0);
              size_d       = font_lo_d;
              style_d      = card_style;
            end
          end
        endcase
      end else begin
        case (data_byte_i) inside
          BYTE_NUL: begin
            if (chain_start_i) skip_d = SKIP_HEADER;
          end
          BYTE_FORMFEED: begin
            has_tok = 1'b1;
            if (mode_q == MODE_HTML) begin
              cmd.kind  = TOK_PAGEBREAK;
              cmd.value = '0;
            end
          end
          BYTE_CR: begin
            has_tok   = 1'b1;
            cmd.kind  = TOK_LINEBREAK;
            cmd.value = '0;
          end
          BYTE_GRAPHIC: begin
            has_tok   = 1'b1;
            cmd.kind  = TOK_IMAGE;
            cmd.value = '0;
            skip_d    = SKIP_GRAPHIC;
          end
          BYTE_RULER: begin
            has_tok   = (mode_q == MODE_RTF);
            cmd.kind  = TOK_PARAGRAPH;
            cmd.value = '0;
            skip_d    = SKIP_RULER;
          end
          BYTE_CARD: begin
            capturing_d = 1'b1;
            cap_idx_d   = '0;
          end
          BYTE_SKIP_A, BYTE_SKIP_B: begin
            skip_d = SKIP_ESCAPE;
          end
          BYTE_SKIP_C: begin
            skip_d = SKIP_LONG;
          end
          BYTE_LBRACE, BYTE_RBRACE: begin
            has_tok = 1'b1;
            if (mode_q == MODE_RTF) cmd.kind = TOK_BRACE;
          end
          default: begin
            has_tok = 1'b1;
          end
        endcase
      end
    end
  end

  assign push_o = accept && has_tok;
  assign cmd_o  = cmd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= MODE_RTF;
      skip_q      <= '0;
      capturing_q <= 1'b0;
      cap_idx_q   <= '0;
      font_lo_q   <= '0;
      style_q     <= '0;
      size_q      <= '0;
    end else begin
      if (cfg_we_i) mode_q <= mode_e'(cfg_data_i);
      skip_q      <= skip_d;
      capturing_q <= capturing_d;
      cap_idx_q   <= cap_idx_d;
      font_lo_q   <= font_lo_d;
      style_q     <= style_d;
      size_q      <= size_d;
    end
  end

endmodule

// ===== rtl/core/wpet_fifo.sv =====
// small command queue between front and back end
// depends on wpet_pkg
module wpet_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  wpet_pkg::cmd_t       push_data_i,
  input  logic                 pop_i,
  output wpet_pkg::cmd_t       pop_data_o,
  output wpet_pkg::fifo_stat_t stat_o
);
  import wpet_pkg::*;

  cmd_t              mem_q [FifoDepth];
  logic [FifoAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [FifoAw:0]   count_q;

  assign stat_o.full  = (count_q == (FifoAw+1)'(FifoDepth));
  assign stat_o.empty = (count_q == '0);
  assign pop_data_o   = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_ptr_q] <= push_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) wr_ptr_q <= wr_ptr_q + FifoAw'(1);
      if (pop_i)  rd_ptr_q <= rd_ptr_q + FifoAw'(1);
      case ({push_i, pop_i})
        2'b10:   count_q <= count_q + (FifoAw+1)'(1);
        2'b01:   count_q <= count_q - (FifoAw+1)'(1);
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/wpet_back.sv =====
// back end: expands queued commands into tokens, one word per cycle while out_ready_i is high
// depends on wpet_pkg
module wpet_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  wpet_pkg::cmd_t       head_i,
  input  wpet_pkg::fifo_stat_t stat_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [3:0]           token_kind_o,
  output logic [7:0]           token_value_o,
  output logic                 last_o
);
  import wpet_pkg::*;

  // style bit number of the lowest set mask bit (mask bit i is style bit i+1)
  function automatic logic [2:0] low_idx(input logic [StyleW-1:0] m);
    logic [2:0] r;
    r = '0;
    for (int i = StyleW - 1; i >= 0; i--) begin
      if (m[i]) r = 3'(i + 1);
    end
    return r;
  endfunction

  logic              cur_valid_q;
  cmd_t              cur_q;
  tok_kind_e         kind;
  logic [7:0]        value;
  logic              last, fire, done;
  logic [StyleW-1:0] off_rest, on_rest;

  assign off_rest = cur_q.off_mask & (cur_q.off_mask - StyleW'(1));
  assign on_rest  = cur_q.on_mask & (cur_q.on_mask - StyleW'(1));

  always_comb begin
    kind  = cur_q.kind;
    value = cur_q.value;
    last  = 1'b1;
    if (cur_q.is_card) begin
      if (cur_q.size_chg) begin
        kind = TOK_FONTSIZE;
        last = (cur_q.off_mask == '0) && (cur_q.on_mask == '0);
      end else if (cur_q.off_mask != '0) begin
        kind  = TOK_STYLE_OFF;
        value = {5'd0, low_idx(cur_q.off_mask)};
        last  = (off_rest == '0) && (cur_q.on_mask == '0);
      end else begin
        kind  = TOK_STYLE_ON;
        value = {5'd0, low_idx(cur_q.on_mask)};
        last  = (on_rest == '0);
      end
    end
  end

  assign fire  = cur_valid_q && out_ready_i;
  assign done  = !cur_valid_q || (fire && last);
  assign pop_o = done && !stat_i.empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
    end else if (done) begin
      cur_valid_q <= !stat_i.empty;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      if (!stat_i.empty) cur_q <= head_i;
    end else if (fire) begin
      // drop the token just taken from the card
      if (cur_q.size_chg)              cur_q.size_chg <= 1'b0;
      else if (cur_q.off_mask != '0)   cur_q.off_mask <= off_rest;
      else                             cur_q.on_mask  <= on_rest;
    end
  end

  assign out_valid_o   = cur_valid_q;
  assign token_kind_o  = kind;
  assign token_value_o = value;
  assign last_o        = last;

endmodule

// ===== rtl/core/word_processor_escape_tokenizer.sv =====
// escape tokenizer for a word-processor page chain: top level
// holds wpet_front, wpet_fifo and wpet_back; depends on wpet_pkg
//
// usage:
//   input channel: in_valid_i/in_ready_o carry one payload byte (data_byte_i)
//   and chain_start_i, set on the first byte of a page chain
//   output channel: out_valid_o/out_ready_i carry one token word
//   (token_kind_o, token_value_o, last_o); last_o marks the final token of a byte
//   cfg_we_i/cfg_data_i write output_mode (0 plain, 1 html, 2 rtf) into a register
//   throughput: one byte per cycle unless the command queue is full; one token per
//   cycle at the output while out_ready_i is high
//   a font/style escape ends in up to 8 tokens, which the back end drains one per
//   cycle while out_ready_i is high; the 4-entry queue keeps the front taking bytes
//   bytes that make no token (skipped, captured, NUL) take no queue slot
//   in_ready_o drops only when the command queue is full
//   reset: mode rtf, skip/capture/style/size cleared, queue and output empty
//   receiver stall: the current token holds; the queue then fills and stalls input
module word_processor_escape_tokenizer (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [1:0] cfg_data_i,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] data_byte_i,
  input  logic       chain_start_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [3:0] token_kind_o,
  output logic [7:0] token_value_o,
  output logic       last_o
);
  import wpet_pkg::*;

  logic       push, pop;
  cmd_t       push_cmd, head_cmd;
  fifo_stat_t stat;

  wpet_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .in_valid_i    (in_valid_i),
    .data_byte_i   (data_byte_i),
    .chain_start_i (chain_start_i),
    .in_ready_o    (in_ready_o),
    .push_o        (push),
    .cmd_o         (push_cmd),
    .stat_i        (stat)
  );

  wpet_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_cmd),
    .pop_i       (pop),
    .pop_data_o  (head_cmd),
    .stat_o      (stat)
  );

  wpet_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head_cmd),
    .stat_i        (stat),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .token_kind_o  (token_kind_o),
    .token_value_o (token_value_o),
    .last_o        (last_o)
  );

`ifndef SYNTHESIS
  // style tokens name a bit between 1 and 7
  a_style_bit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == TOK_STYLE_OFF || token_kind_o == TOK_STYLE_ON)
    |-> (token_value_o != 8'd0) && (token_value_o <= 8'd7))
    else $error("style token with bad bit number");

  // font size tokens stay within five bits
  a_font_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (token_kind_o == TOK_FONTSIZE) |-> (token_value_o[7:5] == 3'd0))
    else $error("font size out of range");

  // a byte's token burst continues without a gap once started
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && !last_o |=> out_valid_o)
    else $error("token burst broken");

  // the queue never takes a command while full
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !stat.full)
    else $error("command queue overflow");
`endif

endmodule
